### hdl/fdec_pkg.sv
// Shared types and constants of the IPv4 forwarding decision engine.
// Depends on nothing; used by every module of the engine.
package fdec_pkg;

    localparam logic [1:0] ACT_ROUTE_WR = 2'd0;
    localparam logic [1:0] ACT_IFACE_WR = 2'd1;
    localparam logic [1:0] ACT_ARP      = 2'd2;
    localparam logic [1:0] ACT_IPV4     = 2'd3;

    localparam logic [2:0] VRD_UPDATED = 3'd0;
    localparam logic [2:0] VRD_IGNORED = 3'd1;
    localparam logic [2:0] VRD_LOCAL   = 3'd2;
    localparam logic [2:0] VRD_NOROUTE = 3'd3;
    localparam logic [2:0] VRD_TIMEX   = 3'd4;
    localparam logic [2:0] VRD_ARP     = 3'd5;
    localparam logic [2:0] VRD_FORWARD = 3'd6;

    localparam logic [15:0] CSUM_ZERO_SUB = 16'hffff;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  slot;
        logic [31:0] address;
        logic [31:0] mask;
        logic [31:0] next_hop;
        logic [1:0]  port;
        logic        entry_valid;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic        is_reply;
        logic [7:0]  ttl;
        logic [15:0] header_checksum;
    } item_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [1:0]  out_port;
        logic [31:0] hop_ip;
        logic [47:0] hop_mac;
        logic [47:0] source_mac_out;
        logic [7:0]  new_ttl;
        logic [15:0] new_checksum;
        logic [31:0] reply_source_ip;
    } result_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] hop;
        logic [1:0]  port;
        logic [47:0] hop_mac;
    } route_entry_t;

    typedef struct packed {
        logic        own_mac;
        logic        local_hit;
        logic [31:0] reply_ip;
        logic        port_ok;
        logic [47:0] port_mac;
    } iface_status_t;

endpackage

### hdl/fdec_route_mem.sv
// Route table memory: one write port and one read port with registered read data.
// Depends on fdec_pkg for the route entry type.
module fdec_route_mem #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [IW-1:0]         wr_idx,
    input  fdec_pkg::route_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [IW-1:0]         rd_idx,
    output fdec_pkg::route_entry_t rd_data
);

    fdec_pkg::route_entry_t mem [DEPTH];
    fdec_pkg::route_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/fdec_iface_tbl.sv
// Interface table: IP and MAC per interface, with the lookups a frame needs.
// Depends on fdec_pkg for the status type.
module fdec_iface_tbl #(
    parameter int ENTRIES = 4,
    parameter int IW      = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [IW-1:0]         wr_idx,
    input  logic [31:0]           wr_ip,
    input  logic [47:0]           wr_mac,
    input  logic                  wr_use,
    input  logic [47:0]           q_src_mac,
    input  logic [47:0]           q_dst_mac,
    input  logic [31:0]           q_addr,
    input  logic [1:0]            q_port,
    output fdec_pkg::iface_status_t status
);

    logic [31:0]        ip_reg  [ENTRIES];
    logic [47:0]        mac_reg [ENTRIES];
    logic [ENTRIES-1:0] use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_reg <= '0;
        end else if (wr_en) begin
            use_reg[wr_idx] <= wr_use;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ip_reg[wr_idx]  <= wr_ip;
            mac_reg[wr_idx] <= wr_mac;
        end
    end

    always_comb begin
        logic found;
        status = '0;
        found  = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (use_reg[i] && mac_reg[i] == q_src_mac) begin
                status.own_mac = 1'b1;
            end
            if (use_reg[i] && ip_reg[i] == q_addr) begin
                status.local_hit = 1'b1;
            end
            if (!found && use_reg[i] && mac_reg[i] == q_dst_mac) begin
                found           = 1'b1;
                status.reply_ip = ip_reg[i];
            end
            if (use_reg[i] && 32'(i) == {30'd0, q_port}) begin
                status.port_ok  = 1'b1;
                status.port_mac = mac_reg[i];
            end
        end
    end

endmodule

### hdl/fdec_ctrl.sv
// Sequencer of the engine: decodes an item, walks the route memory, decides, holds the result.
// Depends on fdec_pkg; drives fdec_route_mem and fdec_iface_tbl.
module fdec_ctrl #(
    parameter int ROUTE_ENTRIES = 16,
    parameter int IFACE_ENTRIES = 4,
    parameter int LIVE          = 16,
    parameter int IW            = 4,
    parameter int FW            = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fdec_pkg::item_t        in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fdec_pkg::result_t      out_res,
    output logic                   mem_wr_en,
    output logic [IW-1:0]          mem_wr_idx,
    output fdec_pkg::route_entry_t mem_wr_data,
    output logic                   mem_rd_en,
    output logic [IW-1:0]          mem_rd_idx,
    input  fdec_pkg::route_entry_t mem_rd_data,
    output logic                   if_wr_en,
    output logic [FW-1:0]          if_wr_idx,
    output logic [47:0]            q_src_mac,
    output logic [47:0]            q_dst_mac,
    output logic [31:0]            q_addr,
    output logic [1:0]             q_port,
    input  fdec_pkg::iface_status_t if_status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_WALK   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [10:0] ROUTE_LIM = 11'(ROUTE_ENTRIES);
    localparam logic [4:0]  IFACE_LIM = 5'(IFACE_ENTRIES);
    localparam logic [IW:0] LIVE_CNT  = (IW + 1)'(LIVE);
    localparam logic [IW-1:0] LAST_IDX = IW'(LIVE - 1);

    logic [2:0]        state_reg, state_next;
    fdec_pkg::item_t   item_reg;
    logic [LIVE-1:0]   use_reg, use_next;
    logic [IW:0]       rd_cnt_reg, rd_cnt_next;
    logic              cmp_vld_reg;
    logic [IW-1:0]     cmp_idx_reg;
    logic              best_vld_reg, best_vld_next;
    logic [31:0]       best_mask_reg, best_mask_next;
    logic [31:0]       best_hop_reg, best_hop_next;
    logic [1:0]        best_port_reg, best_port_next;
    logic [47:0]       best_mac_reg, best_mac_next;
    fdec_pkg::result_t res_reg, res_next;
    logic              out_vld_reg;
    fdec_pkg::result_t out_reg;
    logic              load_out;
    logic              route_ok, iface_ok, hit;
    logic [7:0]        nt;
    logic [17:0]       sum0;
    logic [16:0]       sum1;
    logic [15:0]       sum2, csum;

    assign route_ok   = {7'd0, item_reg.slot} < ROUTE_LIM;
    assign iface_ok   = {1'b0, item_reg.slot} < IFACE_LIM;
    assign in_ready   = (state_reg == ST_IDLE);
    assign mem_rd_en  = (state_reg == ST_WALK) && (rd_cnt_reg < LIVE_CNT);
    assign mem_rd_idx = rd_cnt_reg[IW-1:0];
    assign if_wr_en   = (state_reg == ST_EXEC) && (item_reg.action == fdec_pkg::ACT_IFACE_WR)
                        && iface_ok;
    assign if_wr_idx  = item_reg.slot[FW-1:0];
    assign q_src_mac  = item_reg.src_mac;
    assign q_dst_mac  = item_reg.dst_mac;
    assign q_addr     = item_reg.address;
    assign q_port     = best_port_reg;
    assign hit        = cmp_vld_reg && use_reg[cmp_idx_reg];
    assign load_out   = (state_reg == ST_DONE) && (!out_vld_reg || out_ready);
    assign out_valid  = out_vld_reg;
    assign out_res    = out_reg;

    assign nt   = item_reg.ttl - 8'd1;
    assign sum0 = {2'd0, ~item_reg.header_checksum} + {2'd0, ~{item_reg.ttl, 8'd0}}
                  + {2'd0, nt, 8'd0};
    assign sum1 = {1'b0, sum0[15:0]} + {15'd0, sum0[17:16]};
    assign sum2 = sum1[15:0] + {15'd0, sum1[16]};
    assign csum = (~sum2 == 16'd0) ? fdec_pkg::CSUM_ZERO_SUB : ~sum2;

    always_comb begin
        state_next     = state_reg;
        use_next       = use_reg;
        rd_cnt_next    = rd_cnt_reg;
        best_vld_next  = best_vld_reg;
        best_mask_next = best_mask_reg;
        best_hop_next  = best_hop_reg;
        best_port_next = best_port_reg;
        best_mac_next  = best_mac_reg;
        res_next       = res_reg;
        mem_wr_en      = 1'b0;
        mem_wr_idx     = item_reg.slot[IW-1:0];
        mem_wr_data    = '{dest: item_reg.address, mask: item_reg.mask, hop: item_reg.next_hop,
                           port: item_reg.port, hop_mac: 48'd0};
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next         = '0;
                res_next.verdict = fdec_pkg::VRD_IGNORED;
                state_next       = ST_DONE;
                rd_cnt_next      = '0;
                best_vld_next    = 1'b0;
                priority if (item_reg.action == fdec_pkg::ACT_ROUTE_WR) begin
                    if (route_ok) begin
                        mem_wr_en                 = 1'b1;
                        use_next[mem_wr_idx]      = item_reg.entry_valid;
                        res_next.verdict          = fdec_pkg::VRD_UPDATED;
                    end
                end else if (item_reg.action == fdec_pkg::ACT_IFACE_WR) begin
                    if (iface_ok) begin
                        res_next.verdict = fdec_pkg::VRD_UPDATED;
                    end
                end else if (if_status.own_mac) begin
                    res_next.verdict = fdec_pkg::VRD_IGNORED;
                end else if (item_reg.action == fdec_pkg::ACT_ARP) begin
                    if (item_reg.is_reply) begin
                        res_next.verdict = fdec_pkg::VRD_UPDATED;
                        state_next       = ST_WALK;
                    end
                end else if (if_status.local_hit) begin
                    res_next.verdict = fdec_pkg::VRD_LOCAL;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (mem_rd_en) begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (item_reg.action == fdec_pkg::ACT_ARP) begin
                    if (hit && mem_rd_data.hop == item_reg.address) begin
                        mem_wr_en           = 1'b1;
                        mem_wr_idx          = cmp_idx_reg;
                        mem_wr_data         = mem_rd_data;
                        mem_wr_data.hop_mac = item_reg.src_mac;
                    end
                end else if (hit
                    && (item_reg.address & mem_rd_data.mask)
                       == (mem_rd_data.dest & mem_rd_data.mask)
                    && (!best_vld_reg || mem_rd_data.mask > best_mask_reg)) begin
                    best_vld_next  = 1'b1;
                    best_mask_next = mem_rd_data.mask;
                    best_hop_next  = mem_rd_data.hop;
                    best_port_next = mem_rd_data.port;
                    best_mac_next  = mem_rd_data.hop_mac;
                end
                if (cmp_vld_reg && cmp_idx_reg == LAST_IDX) begin
                    state_next = (item_reg.action == fdec_pkg::ACT_ARP) ? ST_DONE : ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_next   = '0;
                state_next = ST_DONE;
                priority if (item_reg.ttl == 8'd1) begin
                    res_next.verdict         = fdec_pkg::VRD_TIMEX;
                    res_next.reply_source_ip = if_status.reply_ip;
                end else if (!best_vld_reg) begin
                    res_next.verdict = fdec_pkg::VRD_NOROUTE;
                end else begin
                    res_next.out_port = best_port_reg;
                    res_next.hop_ip   = best_hop_reg;
                    if (best_mac_reg == 48'd0) begin
                        res_next.verdict = fdec_pkg::VRD_ARP;
                    end else begin
                        res_next.verdict        = fdec_pkg::VRD_FORWARD;
                        res_next.hop_mac        = best_mac_reg;
                        res_next.source_mac_out = if_status.port_ok ? if_status.port_mac
                                                                    : item_reg.src_mac;
                        res_next.new_ttl        = nt;
                        res_next.new_checksum   = csum;
                    end
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            use_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
            best_vld_reg <= 1'b0;
            rd_cnt_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            use_reg      <= use_next;
            cmp_vld_reg  <= mem_rd_en;
            best_vld_reg <= best_vld_next;
            rd_cnt_reg   <= rd_cnt_next;
            if (load_out) begin
                out_vld_reg <= 1'b1;
            end else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
        cmp_idx_reg    <= mem_rd_idx;
        best_mask_reg  <= best_mask_next;
        best_hop_reg   <= best_hop_next;
        best_port_reg  <= best_port_next;
        best_mac_reg   <= best_mac_next;
        res_reg        <= res_next;
        if (load_out) begin
            out_reg <= res_reg;
        end
    end

`ifndef SYNTHESIS
    a_rmw_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_idx != mem_rd_idx))
        else $error("route write and read hit the same entry");
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted item did not start execution");
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (out_vld_reg && state_reg == ST_IDLE))
        else $error("finished result not presented");
    a_walk_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmp_vld_reg && cmp_idx_reg == LAST_IDX) |=> (state_reg != ST_WALK))
        else $error("route walk ran past last entry");
`endif

endmodule

### hdl/ipv4_forwarding_decision_engine_core.sv
// Top level of the IPv4 forwarding decision engine: stream ports and instances.
// Depends on fdec_pkg, fdec_route_mem, fdec_iface_tbl and fdec_ctrl.
//
// Channel  Dir  Handshake          Content
// s_       in   s_tvalid/s_tready  s_tuser action, s_tdata item fields
// m_       out  m_tvalid/m_tready  m_tuser verdict, m_tdata result fields
//
// A route write, interface write, ignored or local item skips walk and decide.
// A routed packet walks the route memory one entry a cycle, then decides; an ARP
// reply walks it too but skips the decide state. LIVE is ROUTE_ENTRIES capped at
// the 16 slots that the slot field reaches, and the single read port sets the pace.
// Reset clears all in-use bits; no clearing pass is needed.
// A new item is taken while the previous result waits in the output register.
module ipv4_forwarding_decision_engine_core #(
    parameter int ROUTE_ENTRIES = 16,
    parameter int IFACE_ENTRIES = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot, address, mask, next_hop, port, entry_valid, src_mac, dst_mac,
    // is_reply, ttl, header_checksum
    input  logic [223:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_port, hop_ip, hop_mac, source_mac_out, new_ttl, new_checksum,
    // reply_source_ip, zero fill
    output logic [191:0] m_tdata,
    // verdict
    output logic [2:0]   m_tuser
);

    localparam int LIVE = (ROUTE_ENTRIES < 16) ? ROUTE_ENTRIES : 16;
    localparam int IW   = (LIVE > 1) ? $clog2(LIVE) : 1;
    localparam int FW   = (IFACE_ENTRIES > 1) ? $clog2(IFACE_ENTRIES) : 1;

    fdec_pkg::item_t        item;
    fdec_pkg::result_t      res;
    fdec_pkg::route_entry_t wr_data, rd_data;
    fdec_pkg::iface_status_t if_status;
    logic                   wr_en, rd_en, if_wr_en;
    logic [IW-1:0]          wr_idx, rd_idx;
    logic [FW-1:0]          if_wr_idx;
    logic [47:0]            q_src_mac, q_dst_mac;
    logic [31:0]            q_addr;
    logic [1:0]             q_port;
    logic                   s_use_reg;
    logic                   wr_use_bit;

    assign item.action          = s_tuser;
    assign item.slot            = s_tdata[3:0];
    assign item.address         = s_tdata[35:4];
    assign item.mask            = s_tdata[67:36];
    assign item.next_hop        = s_tdata[99:68];
    assign item.port            = s_tdata[101:100];
    assign item.entry_valid     = s_tdata[102];
    assign item.src_mac         = s_tdata[150:103];
    assign item.dst_mac         = s_tdata[198:151];
    assign item.is_reply        = s_tdata[199];
    assign item.ttl             = s_tdata[207:200];
    assign item.header_checksum = s_tdata[223:208];

    assign m_tuser = res.verdict;
    assign m_tdata = {6'd0, res.reply_source_ip, res.new_checksum, res.new_ttl,
                      res.source_mac_out, res.hop_mac, res.hop_ip, res.out_port};

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s_use_reg <= item.entry_valid;
        end
    end

    assign wr_use_bit = s_use_reg;

    fdec_route_mem #(.DEPTH(LIVE), .IW(IW)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    fdec_iface_tbl #(.ENTRIES(IFACE_ENTRIES), .IW(FW)) u_iface (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (if_wr_en),
        .wr_idx    (if_wr_idx),
        .wr_ip     (q_addr),
        .wr_mac    (q_src_mac),
        .wr_use    (wr_use_bit),
        .q_src_mac (q_src_mac),
        .q_dst_mac (q_dst_mac),
        .q_addr    (q_addr),
        .q_port    (q_port),
        .status    (if_status)
    );

    fdec_ctrl #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES),
        .IFACE_ENTRIES (IFACE_ENTRIES),
        .LIVE          (LIVE),
        .IW            (IW),
        .FW            (FW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_item     (item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res),
        .mem_wr_en   (wr_en),
        .mem_wr_idx  (wr_idx),
        .mem_wr_data (wr_data),
        .mem_rd_en   (rd_en),
        .mem_rd_idx  (rd_idx),
        .mem_rd_data (rd_data),
        .if_wr_en    (if_wr_en),
        .if_wr_idx   (if_wr_idx),
        .q_src_mac   (q_src_mac),
        .q_dst_mac   (q_dst_mac),
        .q_addr      (q_addr),
        .q_port      (q_port),
        .if_status   (if_status)
    );

endmodule

### test/tb.sv
// Self-checking testbench for the IPv4 forwarding decision engine core.
// Depends on fdec_pkg and ipv4_forwarding_decision_engine_core; drives items of all
// four actions and compares every verdict with an internal table-based predictor.
`timescale 1ns / 1ps

class fwd_scoreboard;
    logic [31:0] rt_dest [16];
    logic [31:0] rt_mask [16];
    logic [31:0] rt_hop [16];
    logic [1:0]  rt_port [16];
    logic [47:0] rt_mac [16];
    bit          rt_use [16];
    logic [31:0] if_ip [4];
    logic [47:0] if_mac [4];
    bit          if_use [4];
    fdec_pkg::result_t verdicts_due[$];
    int          errors;

    function new();
        for (int i = 0; i < 16; i++) begin
            rt_dest[i] = '0; rt_mask[i] = '0; rt_hop[i] = '0;
            rt_port[i] = '0; rt_mac[i] = '0; rt_use[i] = 0;
        end
        for (int i = 0; i < 4; i++) begin
            if_ip[i] = '0; if_mac[i] = '0; if_use[i] = 0;
        end
        errors = 0;
    endfunction

    function logic [15:0] ttl_csum(logic [15:0] cs, logic [7:0] t, logic [7:0] nt);
        logic [31:0] s;
        logic [15:0] r;
        s = {16'h0, ~cs} + {16'h0, ~{t, 8'h00}} + {16'h0, nt, 8'h00};
        s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        r = ~s[15:0];
        return (r == 16'h0) ? fdec_pkg::CSUM_ZERO_SUB : r;
    endfunction

    function fdec_pkg::result_t decide(fdec_pkg::item_t it);
        fdec_pkg::result_t r;
        int best;
        logic [7:0] nt;
        r = '0;
        best = -1;
        if (it.action == fdec_pkg::ACT_ROUTE_WR) begin
            rt_dest[it.slot] = it.address;
            rt_mask[it.slot] = it.mask;
            rt_hop[it.slot]  = it.next_hop;
            rt_port[it.slot] = it.port;
            rt_mac[it.slot]  = '0;
            rt_use[it.slot]  = it.entry_valid;
            r.verdict = fdec_pkg::VRD_UPDATED;
            return r;
        end
        if (it.action == fdec_pkg::ACT_IFACE_WR) begin
            if (it.slot >= 4) begin
                r.verdict = fdec_pkg::VRD_IGNORED;
                return r;
            end
            if_ip[it.slot]  = it.address;
            if_mac[it.slot] = it.src_mac;
            if_use[it.slot] = it.entry_valid;
            r.verdict = fdec_pkg::VRD_UPDATED;
            return r;
        end
        for (int i = 0; i < 4; i++) begin
            if (if_use[i] && if_mac[i] == it.src_mac) begin
                r.verdict = fdec_pkg::VRD_IGNORED;
                return r;
            end
        end
        if (it.action == fdec_pkg::ACT_ARP) begin
            if (!it.is_reply) begin
                r.verdict = fdec_pkg::VRD_IGNORED;
                return r;
            end
            for (int i = 0; i < 16; i++) begin
                if (rt_use[i] && rt_hop[i] == it.address) rt_mac[i] = it.src_mac;
            end
            r.verdict = fdec_pkg::VRD_UPDATED;
            return r;
        end
        for (int i = 0; i < 4; i++) begin
            if (if_use[i] && if_ip[i] == it.address) begin
                r.verdict = fdec_pkg::VRD_LOCAL;
                return r;
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (rt_use[i] && ((it.address & rt_mask[i]) == (rt_dest[i] & rt_mask[i]))) begin
                if (best < 0 || rt_mask[i] > rt_mask[best]) best = i;
            end
        end
        if (it.ttl == 8'd1) begin
            r.verdict = fdec_pkg::VRD_TIMEX;
            for (int i = 0; i < 4; i++) begin
                if (if_use[i] && if_mac[i] == it.dst_mac) begin
                    r.reply_source_ip = if_ip[i];
                    break;
                end
            end
            return r;
        end
        if (best < 0) begin
            r.verdict = fdec_pkg::VRD_NOROUTE;
            return r;
        end
        r.out_port = rt_port[best];
        r.hop_ip   = rt_hop[best];
        if (rt_mac[best] == '0) begin
            r.verdict = fdec_pkg::VRD_ARP;
            return r;
        end
        nt = it.ttl - 8'd1;
        r.verdict        = fdec_pkg::VRD_FORWARD;
        r.hop_mac        = rt_mac[best];
        r.source_mac_out = if_use[rt_port[best]] ? if_mac[rt_port[best]] : it.src_mac;
        r.new_ttl        = nt;
        r.new_checksum   = ttl_csum(it.header_checksum, it.ttl, nt);
        return r;
    endfunction

    function void note_item(fdec_pkg::item_t it);
        verdicts_due.push_back(decide(it));
    endfunction

    function void check_result(fdec_pkg::result_t got);
        fdec_pkg::result_t want;
        if (verdicts_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result %h", got);
            return;
        end
        want = verdicts_due.pop_front();
        if (got.verdict !== want.verdict || got.out_port !== want.out_port ||
            got.hop_ip !== want.hop_ip || got.hop_mac !== want.hop_mac ||
            got.source_mac_out !== want.source_mac_out || got.new_ttl !== want.new_ttl ||
            got.new_checksum !== want.new_checksum ||
            got.reply_source_ip !== want.reply_source_ip) begin
            errors++;
            if (errors <= 10) $display("Mismatch: expected %h, actual %h", want, got);
        end
    endfunction
endclass

module tb;
    localparam int WATCHDOG_LIMIT = 5000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;
    logic [2:0]   m_tuser;

    fwd_scoreboard sb = new();
    int          sender_idle = 0;
    int          recv_stall = 0;
    int          quiet_cycles = 0;
    logic [31:0] ip_pool [8];
    logic [47:0] mac_pool [6];

    ipv4_forwarding_decision_engine_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        fdec_pkg::item_t   it;
        fdec_pkg::result_t res;
        m_tready <= ($urandom_range(99) >= recv_stall);
        if (aresetn && m_tvalid && m_tready) begin
            res.verdict         = m_tuser;
            res.out_port        = m_tdata[1:0];
            res.hop_ip          = m_tdata[33:2];
            res.hop_mac         = m_tdata[81:34];
            res.source_mac_out  = m_tdata[129:82];
            res.new_ttl         = m_tdata[137:130];
            res.new_checksum    = m_tdata[153:138];
            res.reply_source_ip = m_tdata[185:154];
            sb.check_result(res);
        end
        if (aresetn && s_tvalid && s_tready) begin
            it.action = s_tuser;
            {it.header_checksum, it.ttl, it.is_reply, it.dst_mac, it.src_mac,
             it.entry_valid, it.port, it.next_hop, it.mask, it.address, it.slot} = s_tdata;
            sb.note_item(it);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else quiet_cycles <= quiet_cycles + 1;
    end

    function automatic fdec_pkg::item_t mk(logic [1:0] act, logic [3:0] slot,
                                 logic [31:0] addr,
                                 logic [31:0] msk, logic [31:0] nh, logic [1:0] prt,
                                 logic v, logic [47:0] smac, logic [47:0] dmac,
                                 logic rep, logic [7:0] t, logic [15:0] cs);
        fdec_pkg::item_t it;
        it.action = act; it.slot = slot; it.address = addr; it.mask = msk;
        it.next_hop = nh; it.port = prt; it.entry_valid = v; it.src_mac = smac;
        it.dst_mac = dmac; it.is_reply = rep; it.ttl = t; it.header_checksum = cs;
        return it;
    endfunction

    function automatic logic [47:0] rmac();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [31:0] prefix_mask(int len);
        return (len == 0) ? 32'h0 : (32'hffffffff << (32 - len));
    endfunction

    function automatic fdec_pkg::item_t rnd_item();
        fdec_pkg::item_t it;
        int sel;
        it = mk(2'($urandom), 4'($urandom), $urandom, $urandom, $urandom, 2'($urandom),
                1'($urandom), rmac(), rmac(), 1'($urandom), 8'($urandom), 16'($urandom));
        if ($urandom_range(99) < 10) return it;
        sel = $urandom_range(99);
        it.src_mac = mac_pool[$urandom_range(5)];
        if ($urandom_range(3) == 0) it.src_mac = rmac();
        it.dst_mac = ($urandom_range(1) == 0) ? mac_pool[$urandom_range(5)] : rmac();
        if (sel < 15) begin
            it.action = fdec_pkg::ACT_ROUTE_WR;
            it.address = ip_pool[$urandom_range(7)];
            it.mask = prefix_mask($urandom_range(32));
            it.next_hop = ip_pool[$urandom_range(7)];
            it.entry_valid = ($urandom_range(5) != 0);
        end else if (sel < 25) begin
            it.action = fdec_pkg::ACT_IFACE_WR;
            it.slot = ($urandom_range(4) == 0) ? it.slot : 4'($urandom_range(3));
            it.address = ip_pool[$urandom_range(7)];
            it.entry_valid = ($urandom_range(4) != 0);
        end else if (sel < 45) begin
            it.action = fdec_pkg::ACT_ARP;
            it.address = ip_pool[$urandom_range(7)];
            it.is_reply = ($urandom_range(4) != 0);
            it.src_mac = rmac();
        end else begin
            it.action = fdec_pkg::ACT_IPV4;
            it.address = ip_pool[$urandom_range(7)];
            if ($urandom_range(1) == 0) it.address[7:0] = 8'($urandom);
            if ($urandom_range(2) == 0) it.src_mac = rmac();
            case ($urandom_range(9))
                0: it.ttl = 8'd1;
                1: it.ttl = 8'd0;
                default: it.ttl = 8'($urandom);
            endcase
        end
        return it;
    endfunction

    task automatic send(fdec_pkg::item_t it);
        while ($urandom_range(99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {it.header_checksum, it.ttl, it.is_reply, it.dst_mac, it.src_mac,
                     it.entry_valid, it.port, it.next_hop, it.mask, it.address, it.slot};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    localparam logic [47:0] M0 = 48'h020000000010, M1 = 48'h020000000011,
                            M2 = 48'h020000000012;
    localparam logic [31:0] H1 = 32'h0a0100fe, H2 = 32'h0a0200fe;

    initial begin
        int idle_set [4];
        int stall_set [4];
        idle_set  = '{0, 71, 0, 36};
        stall_set = '{0, 0, 71, 36};
        for (int i = 0; i < 8; i++) ip_pool[i] = $urandom;
        for (int i = 0; i < 6; i++) mac_pool[i] = rmac();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(mk(fdec_pkg::ACT_IFACE_WR, 0, 32'h0a000001, 0, 0, 0, 1, M0, 0, 0, 0, 0));
        send(mk(fdec_pkg::ACT_IFACE_WR, 1, 32'h0a010001, 0, 0, 0, 1, M1, 0, 0, 0, 0));
        send(mk(fdec_pkg::ACT_IFACE_WR, 2, 32'h0a020001, 0, 0, 0, 1, M2, 0, 0, 0, 0));
        send(mk(fdec_pkg::ACT_IFACE_WR, 9, 32'h0a090001, 0, 0, 0, 1, M2, 0, 0, 0, 0));
        send(mk(fdec_pkg::ACT_IPV4, 0, 32'h08080808, 0, 0, 0, 0, 48'h5, 0, 0, 64,
                16'h1234));
        send(mk(fdec_pkg::ACT_ROUTE_WR, 0, 0, 0, 32'h0a0000fe, 0, 1, 0, 0, 0, 0, 0));
        send(mk(fdec_pkg::ACT_ROUTE_WR, 1, 32'hc0a80000, 32'hffff0000, H1, 1, 1,
                0, 0, 0, 0, 0));
        send(mk(fdec_pkg::ACT_ROUTE_WR, 2, 32'hc0a80100, 32'hffffff00, H2, 3, 1,
                0, 0, 0, 0, 0));
        send(mk(fdec_pkg::ACT_ROUTE_WR, 3, 32'hc0a80100, 32'hffffff00, 32'h0a020063, 2, 1,
                0, 0, 0, 0, 0));
        send(mk(fdec_pkg::ACT_IPV4, 0, 32'hc0a80105, 0, 0, 0, 0, 48'h5, 0, 0, 64,
                16'h1234));
        send(mk(fdec_pkg::ACT_ARP, 0, H2, 0, 0, 0, 0, 48'haa0000000001, 0, 0, 0, 0));
        send(mk(fdec_pkg::ACT_ARP, 0, H2, 0, 0, 0, 0, 48'haa0000000001, 0, 1, 0, 0));
        send(mk(fdec_pkg::ACT_IPV4, 0, 32'hc0a80105, 0, 0, 0, 0, 48'h5, 0, 0, 2,
                16'hfeff));
        send(mk(fdec_pkg::ACT_ARP, 0, H1, 0, 0, 0, 0, 48'hbb0000000002, 0, 1, 0, 0));
        send(mk(fdec_pkg::ACT_IPV4, 0, 32'hc0a80707, 0, 0, 0, 0, 48'h5, 0, 0, 0,
                16'hffff));
        send(mk(fdec_pkg::ACT_IPV4, 0, 32'h0a000001, 0, 0, 0, 0, 48'h5, 0, 0, 64, 0));
        send(mk(fdec_pkg::ACT_IPV4, 0, 32'hc0a80707, 0, 0, 0, 0, M0, 0, 0, 64, 0));
        send(mk(fdec_pkg::ACT_ARP, 0, H1, 0, 0, 0, 0, M2, 0, 1, 0, 0));
        send(mk(fdec_pkg::ACT_IPV4, 0, 32'hc0a80707, 0, 0, 0, 0, 48'h5, M1, 0, 1, 0));
        send(mk(fdec_pkg::ACT_IPV4, 0, 32'hc0a80707, 0, 0, 0, 0, 48'h5, 48'h7, 0, 1, 0));
        send(mk(fdec_pkg::ACT_ROUTE_WR, 15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 3, 0,
                0, 0, 0, 0, 0));
        send(mk(fdec_pkg::ACT_ROUTE_WR, 0, 0, 0, 32'h0a0000fe, 0, 0, 0, 0, 0, 0, 0));
        send(mk(fdec_pkg::ACT_IPV4, 0, 32'h08080808, 0, 0, 0, 0, 48'h5, 0, 0, 64, 0));
        send(mk(fdec_pkg::ACT_IPV4, 15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 3, 1,
                48'hffffffffffff, 48'hffffffffffff, 1, 8'hff, 16'hffff));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle = idle_set[ph];
            recv_stall  = stall_set[ph];
            for (int n = 0; n < 125; n++) send(rnd_item());
            drain();
        end

        if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

### sim.f
hdl/fdec_pkg.sv
hdl/fdec_route_mem.sv
hdl/fdec_iface_tbl.sv
hdl/fdec_ctrl.sv
hdl/ipv4_forwarding_decision_engine_core.sv
test/tb.sv
